### rtl/table_log2_fixed_point_assert.svh
// Assertion macros for the verification files of table_log2_fixed_point.
// Needs nothing else; the checker module tl2_checker takes it in with an include.
`ifndef TABLE_LOG2_FIXED_POINT_ASSERT_SVH
`define TABLE_LOG2_FIXED_POINT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TL2_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TL2_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### rtl/tl2_pkg.sv
// Package for table_log2_fixed_point: widths, constants and lookup tables.
// Used by the interfaces, the multiplier and the top level; depends on nothing.
package tl2_pkg;

    localparam int OPERAND_W        = 32;
    localparam int LOG_W            = 42;
    localparam int LV_FRACTION_BITS = 37;
    localparam int Q_FRAC           = 37;
    localparam int X2_W             = 41;
    localparam int X3_W             = 54;
    localparam int DMAG_W           = 48;
    localparam int C0_W             = 60;
    localparam int SMAG_W           = 62;
    localparam int M1_W             = 55;
    localparam int CM_W             = 35;
    localparam int SUM_W            = 45;
    localparam int VAL_W            = 44;

    localparam logic [9:0]  MUL1_BIAS  = 10'd257;
    localparam logic [13:0] MUL2_BIAS  = 14'd8055;
    localparam logic [6:0]  STEP2_LAST = 7'd70;

    localparam logic [C0_W-1:0]   C0_MAG_Q60 = 60'd831378445473380096;
    localparam logic [SMAG_W-1:0] C1_MAG_Q60 = 62'd2306615731682419200;
    localparam logic [LOG_W-1:0]  LOG_MAX    = {LOG_W{1'b1}};

    typedef struct packed {
        logic pp_en;
        logic sum_en;
    } tl2_mul_ctl_t;

    typedef struct packed {
        logic [4:0]           lz;
        logic [OPERAND_W-1:0] xn;
    } tl2_norm_t;

    localparam logic [7:0] STEP1_MUL [64] = '{
        8'd255, 8'd248, 8'd240, 8'd233, 8'd225, 8'd218, 8'd212, 8'd205,
        8'd199, 8'd192, 8'd186, 8'd180, 8'd175, 8'd169, 8'd164, 8'd158,
        8'd153, 8'd148, 8'd143, 8'd138, 8'd134, 8'd129, 8'd125, 8'd120,
        8'd116, 8'd112, 8'd108, 8'd104, 8'd100, 8'd96,  8'd92,  8'd88,
        8'd85,  8'd81,  8'd78,  8'd74,  8'd71,  8'd68,  8'd65,  8'd62,
        8'd59,  8'd56,  8'd53,  8'd50,  8'd47,  8'd44,  8'd41,  8'd39,
        8'd36,  8'd33,  8'd31,  8'd28,  8'd26,  8'd24,  8'd21,  8'd19,
        8'd17,  8'd14,  8'd12,  8'd10,  8'd8,   8'd6,   8'd4,   8'd2
    };

    localparam logic [31:0] STEP1_LOG [64] = '{
        32'd536870912,  32'd682398916,  32'd937091716,  32'd1103362014,
        32'd1382486880, 32'd1570799997, 32'd1664072623, 32'd1872638678,
        32'd1983759008, 32'd2213741774, 32'd2343750303, 32'd2482852922,
        32'd2516421264, 32'd2672857097, 32'd2721242383, 32'd2895923748,
        32'd2959916243, 32'd3031281479, 32'd3110202637, 32'd3196869810,
        32'd3164538868, 32'd3265651333, 32'd3245145759, 32'd3361388697,
        32'd3353276123, 32'd3350864557, 32'd3354278275, 32'd3363645664,
        32'd3379099398, 32'd3400776639, 32'd3428819239, 32'd3463373953,
        32'd3359437008, 32'd3405756636, 32'd3310825865, 32'd3369405046,
        32'd3283863116, 32'd3202468219, 32'd3125297270, 32'd3052429348,
        32'd2983945771, 32'd2919930186, 32'd2860468654, 32'd2805649749,
        32'd2755564656, 32'd2710307269, 32'd2669974306, 32'd2466913573,
        32'd2435010941, 32'd2408305329, 32'd2214485088, 32'd2196683046,
        32'd2008902480, 32'd1823597751, 32'd1818795892, 32'd1639837179,
        32'd1463481486, 32'd1472347728, 32'd1302668303, 32'd1135729139,
        32'd971571443,  32'd810237358,  32'd651769995,  32'd496213457
    };

    localparam logic [7:0] STEP2_MUL [71] = '{
        8'd137, 8'd136, 8'd134, 8'd132, 8'd130, 8'd128, 8'd126, 8'd124,
        8'd122, 8'd120, 8'd118, 8'd116, 8'd114, 8'd112, 8'd110, 8'd108,
        8'd106, 8'd104, 8'd102, 8'd100, 8'd98,  8'd96,  8'd94,  8'd92,
        8'd90,  8'd88,  8'd86,  8'd84,  8'd82,  8'd80,  8'd78,  8'd76,
        8'd74,  8'd72,  8'd70,  8'd68,  8'd66,  8'd64,  8'd62,  8'd60,
        8'd58,  8'd56,  8'd54,  8'd52,  8'd50,  8'd48,  8'd47,  8'd45,
        8'd43,  8'd41,  8'd39,  8'd37,  8'd35,  8'd33,  8'd31,  8'd29,
        8'd27,  8'd25,  8'd23,  8'd21,  8'd19,  8'd17,  8'd15,  8'd13,
        8'd11,  8'd10,  8'd8,   8'd6,   8'd4,   8'd2,   8'd0
    };

    localparam logic [31:0] STEP2_LOG [71] = '{
        32'd0,          32'd24205884,   32'd72626518,   32'd121058980,
        32'd169503274,  32'd217959408,  32'd266427385,  32'd314907214,
        32'd363398898,  32'd411902444,  32'd460417859,  32'd508945146,
        32'd557484313,  32'd606035366,  32'd654598309,  32'd703173149,
        32'd751759892,  32'd800358543,  32'd848969109,  32'd897591595,
        32'd946226007,  32'd994872351,  32'd1043530633, 32'd1092200858,
        32'd1140883032, 32'd1189577163, 32'd1238283254, 32'd1287001312,
        32'd1335731344, 32'd1384473354, 32'd1433227349, 32'd1481993334,
        32'd1530771317, 32'd1579561301, 32'd1628363294, 32'd1677177302,
        32'd1726003329, 32'd1774841383, 32'd1823691468, 32'd1872553592,
        32'd1921427759, 32'd1970313977, 32'd2019212250, 32'd2068122585,
        32'd2117044987, 32'd2165979464, 32'd2190451231, 32'd2239403829,
        32'd2288368515, 32'd2337345296, 32'd2386334178, 32'd2435335166,
        32'd2484348266, 32'd2533373485, 32'd2582410828, 32'd2631460302,
        32'd2680521912, 32'd2729595665, 32'd2778681566, 32'd2827779622,
        32'd2876889838, 32'd2926012220, 32'd2975146776, 32'd3024293509,
        32'd3073452428, 32'd3098036458, 32'd3147213665, 32'd3196403071,
        32'd3245604684, 32'd3294818508, 32'd3344044550
    };

    // Leading-zero count and normalization by a five-step binary search.
    function automatic tl2_norm_t normalize(input logic [OPERAND_W-1:0] x);
        tl2_norm_t res;
        logic [OPERAND_W-1:0] v;
        v = x;
        res.lz = '0;
        if (v[31:16] == '0)
        begin
            v = {v[15:0], 16'd0};
            res.lz[4] = 1'b1;
        end
        if (v[31:24] == '0)
        begin
            v = {v[23:0], 8'd0};
            res.lz[3] = 1'b1;
        end
        if (v[31:28] == '0)
        begin
            v = {v[27:0], 4'd0};
            res.lz[2] = 1'b1;
        end
        if (v[31:30] == '0)
        begin
            v = {v[29:0], 2'd0};
            res.lz[1] = 1'b1;
        end
        if (v[31] == 1'b0)
        begin
            v = {v[30:0], 1'b0};
            res.lz[0] = 1'b1;
        end
        res.xn = v;
        return res;
    endfunction

endpackage

### rtl/tl2_if.sv
// Valid/ready channel interfaces for the operand and the result of the log2 block.
// Depends on tl2_pkg for the field widths.
interface tl2_in_if import tl2_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OPERAND_W-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink (input valid, input operand, output ready);
endinterface

interface tl2_out_if import tl2_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LOG_W-1:0] log_value;
    logic             zero_input;

    modport source (output valid, output log_value, output zero_input, input ready);
    modport sink (input valid, input log_value, input zero_input, output ready);
endinterface

### rtl/tl2_wide_mul.sv
// Two-stage wide multiplier: four registered partial products, then sum, round and shift.
// Depends on tl2_pkg for the stage-enable struct.
module tl2_wide_mul import tl2_pkg::*;
#(
    parameter int A_W   = 48,
    parameter int B_W   = 60,
    parameter int A_LO  = 24,
    parameter int B_LO  = 30,
    parameter int SHIFT = 53,
    parameter int RES_W = 55
)
(
    input  logic             clk,
    input  tl2_mul_ctl_t     ctl,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic [RES_W-1:0] product
);

    localparam int A_HI = A_W - A_LO;
    localparam int B_HI = B_W - B_LO;
    localparam int P_W  = A_W + B_W + 1;
    localparam logic [P_W-1:0] RND = P_W'(1) << (SHIFT - 1);

    logic [A_LO+B_LO-1:0] pp_ll_reg, pp_ll_next;
    logic [A_LO+B_HI-1:0] pp_lh_reg, pp_lh_next;
    logic [A_HI+B_LO-1:0] pp_hl_reg, pp_hl_next;
    logic [A_HI+B_HI-1:0] pp_hh_reg, pp_hh_next;
    logic [P_W-1:0]       full_sum;
    logic [RES_W-1:0]     res_reg, res_next;

    assign pp_ll_next = a[A_LO-1:0] * b[B_LO-1:0];
    assign pp_lh_next = a[A_LO-1:0] * b[B_W-1:B_LO];
    assign pp_hl_next = a[A_W-1:A_LO] * b[B_LO-1:0];
    assign pp_hh_next = a[A_W-1:A_LO] * b[B_W-1:B_LO];

    assign full_sum = P_W'(pp_ll_reg)
                    + (P_W'(pp_lh_reg) << B_LO)
                    + (P_W'(pp_hl_reg) << A_LO)
                    + (P_W'(pp_hh_reg) << (A_LO + B_LO))
                    + RND;
    assign res_next = RES_W'(full_sum >> SHIFT);

    always_ff @(posedge clk)
    begin
        if (ctl.pp_en)
        begin
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
        end
        if (ctl.sum_en)
        begin
            res_reg <= res_next;
        end
    end

    assign product = res_reg;

endmodule

### rtl/table_log2_fixed_point.sv
// Top level of the table-based base-2 logarithm of a 32-bit unsigned operand.
// Depends on tl2_pkg, the channel interfaces in tl2_if and tl2_wide_mul.
//
// Each operand transaction yields one result transaction holding log2(operand) as unsigned
// fixed point with FRACTION_BITS fraction bits in a 42-bit field, or a zero flag and a value
// of 0 for a zero operand. The block is a ten-stage pipeline that takes one operand per
// cycle unless the pipeline holds, as described below; a result is offered on the output
// channel once its operand has passed every stage. Leading-zero normalization, the two
// table multiplications, the residual, two split wide multiplications of two stages each,
// the signed sum and the final rounding each own their stages. A stage holds only while it
// and every stage after it are full and the output waits, so empty stages keep filling
// while a finished result waits to be taken.
module table_log2_fixed_point import tl2_pkg::*;
#(
    parameter int FRACTION_BITS = LV_FRACTION_BITS
)
(
    input logic       clk,
    input logic       rst_n,
    tl2_in_if.sink    operand_chan,
    tl2_out_if.source result_chan
);

    localparam int NSTG      = 10;
    localparam int RND_SHIFT = Q_FRAC - FRACTION_BITS;
    localparam logic [VAL_W+1:0] RND_HALF = ((VAL_W + 2)'(1) << RND_SHIFT) >> 1;

    logic [NSTG-1:0] vld_reg, vld_next, vld_in, stage_en;

    tl2_norm_t norm;

    logic [OPERAND_W-1:0] s0_xn_reg;
    logic [4:0]           s0_lz_reg;
    logic                 s0_zero_reg;

    logic [5:0]         i1;
    logic [9:0]         m1f;
    logic [X2_W:0]      x2_full;
    logic [X2_W-1:0]    s1_x2_reg;
    logic [5:0]         s1_i1_reg;
    logic [4:0]         s1_lz_reg;
    logic [31:0]        s1_log1_reg;
    logic               s1_zero_reg;

    logic [6:0]          i2_raw, i2;
    logic [13:0]         m2f;
    logic [X3_W:0]       x3_full;
    logic [4:0]          int_part;
    logic [SUM_W-1:0]    base_next;
    logic [X3_W-1:0]     s2_x3_reg;
    logic signed [SUM_W-1:0] s2_base_reg;
    logic                s2_zero_reg;

    logic                neg_next;
    logic [X3_W-1:0]     diff_below;
    logic [DMAG_W-1:0]   dmag_next;
    logic                s3_neg_reg;
    logic [DMAG_W-1:0]   s3_dmag_reg;
    logic signed [SUM_W-1:0] s3_base_reg;
    logic                s3_zero_reg;

    logic [SMAG_W-1:0]   dmag_scaled, smag_next;
    logic [SMAG_W-1:0]   s4_smag_reg, s5_smag_reg;
    logic                s4_neg_reg, s5_neg_reg, s6_neg_reg, s7_neg_reg;
    logic signed [SUM_W-1:0] s4_base_reg, s5_base_reg, s6_base_reg, s7_base_reg;
    logic                s4_zero_reg, s5_zero_reg, s6_zero_reg, s7_zero_reg;

    logic [M1_W-1:0]     m1;
    logic [CM_W-1:0]     cm;
    tl2_mul_ctl_t        mul1_ctl, mul2_ctl;

    logic signed [SUM_W-1:0] cm_ext, sum_next;
    logic [VAL_W-1:0]    val_next, s8_val_reg;
    logic                s8_zero_reg;

    logic [VAL_W+1:0]    rounded;
    logic [LOG_W-1:0]    log_next, out_log_reg;
    logic                out_zero_reg;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        stage_en[NSTG-1] = !vld_reg[NSTG-1] || result_chan.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    assign vld_in   = {vld_reg[NSTG-2:0], operand_chan.valid};
    assign vld_next = (stage_en & vld_in) | (~stage_en & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign operand_chan.ready = stage_en[0];

    assign norm = normalize(operand_chan.operand);

    assign i1      = s0_xn_reg[30:25];
    assign m1f     = {2'b00, STEP1_MUL[i1]} + MUL1_BIAS;
    assign x2_full = s0_xn_reg * m1f;

    assign i2_raw    = s1_x2_reg[34:28];
    assign i2        = (i2_raw > STEP2_LAST) ? STEP2_LAST : i2_raw;
    assign m2f       = {6'd0, STEP2_MUL[i2]} + MUL2_BIAS;
    assign x3_full   = s1_x2_reg * m2f;
    assign int_part  = 5'd31 - s1_lz_reg;
    assign base_next = {3'b000, int_part, s1_i1_reg, 31'd0}
                     + {11'd0, s1_log1_reg, 2'b00}
                     + {13'd0, STEP2_LOG[i2]}
                     - (SUM_W'(1) << 31);

    assign neg_next   = !s2_x3_reg[X3_W-1];
    assign diff_below = (X3_W'(1) << (X3_W - 1)) - s2_x3_reg;
    assign dmag_next  = neg_next ? diff_below[DMAG_W-1:0] : s2_x3_reg[DMAG_W-1:0];

    assign dmag_scaled = {{(SMAG_W - DMAG_W - 7){1'b0}}, s3_dmag_reg, 7'd0};
    assign smag_next   = s3_neg_reg ? (C1_MAG_Q60 + dmag_scaled) : (C1_MAG_Q60 - dmag_scaled);

    assign mul1_ctl.pp_en  = stage_en[4];
    assign mul1_ctl.sum_en = stage_en[5];
    assign mul2_ctl.pp_en  = stage_en[6];
    assign mul2_ctl.sum_en = stage_en[7];

    tl2_wide_mul #(
        .A_W   (DMAG_W),
        .B_W   (C0_W),
        .A_LO  (24),
        .B_LO  (30),
        .SHIFT (53),
        .RES_W (M1_W)
    ) u_mul1 (
        .clk     (clk),
        .ctl     (mul1_ctl),
        .a       (s3_dmag_reg),
        .b       (C0_MAG_Q60),
        .product (m1)
    );

    tl2_wide_mul #(
        .A_W   (M1_W),
        .B_W   (SMAG_W),
        .A_LO  (28),
        .B_LO  (31),
        .SHIFT (83),
        .RES_W (CM_W)
    ) u_mul2 (
        .clk     (clk),
        .ctl     (mul2_ctl),
        .a       (m1),
        .b       (s5_smag_reg),
        .product (cm)
    );

    assign cm_ext   = $signed({{(SUM_W - CM_W){1'b0}}, cm});
    assign sum_next = s7_neg_reg ? (s7_base_reg - cm_ext) : (s7_base_reg + cm_ext);
    assign val_next = sum_next[SUM_W-1] ? '0 : sum_next[VAL_W-1:0];

    assign rounded  = ({2'b00, s8_val_reg} + RND_HALF) >> RND_SHIFT;
    assign log_next = s8_zero_reg ? '0 :
                      (rounded > {4'd0, LOG_MAX}) ? LOG_MAX : rounded[LOG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s0_xn_reg   <= norm.xn;
            s0_lz_reg   <= norm.lz;
            s0_zero_reg <= (operand_chan.operand == '0);
        end
        if (stage_en[1])
        begin
            s1_x2_reg   <= x2_full[X2_W-1:0];
            s1_i1_reg   <= i1;
            s1_lz_reg   <= s0_lz_reg;
            s1_log1_reg <= STEP1_LOG[i1];
            s1_zero_reg <= s0_zero_reg;
        end
        if (stage_en[2])
        begin
            s2_x3_reg   <= x3_full[X3_W-1:0];
            s2_base_reg <= $signed(base_next);
            s2_zero_reg <= s1_zero_reg;
        end
        if (stage_en[3])
        begin
            s3_neg_reg  <= neg_next;
            s3_dmag_reg <= dmag_next;
            s3_base_reg <= s2_base_reg;
            s3_zero_reg <= s2_zero_reg;
        end
        if (stage_en[4])
        begin
            s4_smag_reg <= smag_next;
            s4_neg_reg  <= s3_neg_reg;
            s4_base_reg <= s3_base_reg;
            s4_zero_reg <= s3_zero_reg;
        end
        if (stage_en[5])
        begin
            s5_smag_reg <= s4_smag_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_base_reg <= s4_base_reg;
            s5_zero_reg <= s4_zero_reg;
        end
        if (stage_en[6])
        begin
            s6_neg_reg  <= s5_neg_reg;
            s6_base_reg <= s5_base_reg;
            s6_zero_reg <= s5_zero_reg;
        end
        if (stage_en[7])
        begin
            s7_neg_reg  <= s6_neg_reg;
            s7_base_reg <= s6_base_reg;
            s7_zero_reg <= s6_zero_reg;
        end
        if (stage_en[8])
        begin
            s8_val_reg  <= val_next;
            s8_zero_reg <= s7_zero_reg;
        end
        if (stage_en[9])
        begin
            out_log_reg  <= log_next;
            out_zero_reg <= s8_zero_reg;
        end
    end

    assign result_chan.valid      = vld_reg[NSTG-1];
    assign result_chan.log_value  = out_log_reg;
    assign result_chan.zero_input = out_zero_reg;

endmodule

### rtl/tl2_checker.sv
// Port-level checker for table_log2_fixed_point, attached to every instance by bind.
// Depends on tl2_pkg and the macros in table_log2_fixed_point_assert.svh.
`include "table_log2_fixed_point_assert.svh"

module tl2_checker import tl2_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [LOG_W-1:0] log_value,
    input logic             zero_input
);

    logic       in_fire, out_fire;
    logic [4:0] pending_reg, pending_next;

    assign in_fire      = in_valid && in_ready;
    assign out_fire     = out_valid && out_ready;
    assign pending_next = pending_reg + 5'(in_fire) - 5'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A zero operand always reports a value of zero.
    `TL2_ASSERT_IMP(zero_gives_zero, clk, rst_n, out_valid && zero_input, log_value == '0)

    // Every result belongs to an operand transaction that has not been answered yet.
    `TL2_ASSERT_IMP(no_extra_result, clk, rst_n, out_valid, pending_reg != '0)

    // The input side only stalls when the pipeline is full behind a waiting result.
    `TL2_ASSERT_IMP(stall_only_when_full, clk, rst_n, !in_ready, out_valid && !out_ready)

    // A result that is not taken stays on the port unchanged.
    `TL2_ASSERT_NXT(result_holds, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(log_value) && $stable(zero_input))

endmodule

bind table_log2_fixed_point tl2_checker u_tl2_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (operand_chan.valid),
    .in_ready   (operand_chan.ready),
    .out_valid  (result_chan.valid),
    .out_ready  (result_chan.ready),
    .log_value  (result_chan.log_value),
    .zero_input (result_chan.zero_input)
);
